@@ src/name_table_probe_or_claim_macros.svh @@
// ---------------------------------------------------------------------------
// Name table probe-or-claim assertion macros
// Shared property wrappers for the name table checks.
// ---------------------------------------------------------------------------
`ifndef NAME_TABLE_PROBE_OR_CLAIM_MACROS_SVH
`define NAME_TABLE_PROBE_OR_CLAIM_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define NTPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define NTPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ntpc_pkg.sv @@
// ---------------------------------------------------------------------------
// Name table package
// Widths, defaults and the name mask helper for the name table.
// ---------------------------------------------------------------------------
package ntpc_pkg;

  localparam int NAME_W           = 32;
  localparam int LEN_W            = 8;
  localparam int SLOT_INDEX_W     = 6;
  localparam int DEF_TABLE_SLOTS  = 64;

  // Zero every byte at or past the length; lengths of 4 and up keep all bytes.
  function automatic logic [NAME_W-1:0] mask_name(input logic [NAME_W-1:0] word,
                                                  input logic [LEN_W-1:0]  len);
    logic [NAME_W-1:0] res;
    case (len)
      8'd0:    res = '0;
      8'd1:    res = {24'd0, word[7:0]};
      8'd2:    res = {16'd0, word[15:0]};
      8'd3:    res = {8'd0, word[23:0]};
      default: res = word;
    endcase
    return res;
  endfunction

endpackage

@@ src/ntpc_ram.sv @@
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered (read-first).
// ---------------------------------------------------------------------------
module ntpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/ntpc_hash_mod.sv @@
// ---------------------------------------------------------------------------
// Name table home slot unit
// Hash a masked name and reduce it modulo the slot count.
// ---------------------------------------------------------------------------
module ntpc_hash_mod import ntpc_pkg::*; #(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [NAME_W-1:0]              name_word,
  output logic                           done,
  output logic [$clog2(TABLE_SLOTS)-1:0] home
);

  localparam int SLOT_W  = $clog2(TABLE_SLOTS);
  localparam bit IS_POW2 = (TABLE_SLOTS == (1 << SLOT_W));
  // The folded byte sum stays below 2^22 for up to 4096 slots.
  localparam int FOLD_W  = 22;
  localparam int PROD_W  = 2 * FOLD_W;

  // Byte weights 2^7, 2^14 and 2^21 taken modulo the slot count.
  localparam logic [FOLD_W-1:0] W1_C    = FOLD_W'((1 << 7) % TABLE_SLOTS);
  localparam logic [FOLD_W-1:0] W2_C    = FOLD_W'((1 << 14) % TABLE_SLOTS);
  localparam logic [FOLD_W-1:0] W3_C    = FOLD_W'((1 << 21) % TABLE_SLOTS);
  localparam logic [FOLD_W-1:0] SLOTS_C = FOLD_W'(TABLE_SLOTS);
  // floor(2^22 / slots): the quotient estimate is low by at most one.
  localparam logic [FOLD_W-1:0] RECIP_C = FOLD_W'((1 << FOLD_W) / TABLE_SLOTS);

  localparam logic [1:0] LAST_STEP = IS_POW2 ? 2'd0 : 2'd2;

  logic              run_r, run_nxt;
  logic [1:0]        step_r, step_nxt;
  logic [FOLD_W-1:0] fold_r, fold_nxt;
  logic [FOLD_W-1:0] quot_r;
  logic [FOLD_W-1:0] rem_r;
  logic [PROD_W-1:0] prod;
  logic [FOLD_W-1:0] rem_fix;
  logic              last_step;

  // Fold the bytes with their weights; the sum keeps the hash's residue.
  always_comb begin
    fold_nxt = fold_r;
    if (start) begin
      fold_nxt = FOLD_W'(name_word[7:0])
               + FOLD_W'(name_word[15:8])  * W1_C
               + FOLD_W'(name_word[23:16]) * W2_C
               + FOLD_W'(name_word[31:24]) * W3_C;
    end
  end

  // Quotient estimate, then remainder in [0, 2*slots), then one correction.
  assign prod      = PROD_W'(fold_r) * PROD_W'(RECIP_C);
  assign rem_fix   = (rem_r >= SLOTS_C) ? rem_r - SLOTS_C : rem_r;
  assign last_step = (step_r == LAST_STEP);

  always_comb begin
    run_nxt  = run_r;
    step_nxt = step_r;
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = '0;
    end else if (run_r) begin
      step_nxt = step_r + 1'b1;
      if (last_step) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      step_r <= step_nxt;
    end
    fold_r <= fold_nxt;
    quot_r <= prod[PROD_W-1:FOLD_W];
    rem_r  <= fold_r - quot_r * SLOTS_C;
  end

  assign done = run_r && last_step;
  assign home = IS_POW2 ? fold_r[SLOT_W-1:0] : rem_fix[SLOT_W-1:0];

endmodule

@@ src/name_table_probe_or_claim.sv @@
// ---------------------------------------------------------------------------
// Name table probe-or-claim
// Open-addressed hash table of short names with linear probing.
// ---------------------------------------------------------------------------
// Each transaction brings a name of up to four bytes and its length; bytes at
// or past the length count as zero. The block hashes the name to a home slot,
// walks the table from there with wrap, and returns the first slot holding
// the name, or claims the first empty slot it meets and stores the name.
// If no slot matches and none is free, out_table_full is raised with
// out_slot_index zero and the table is left as it was. The table lives in a
// single RAM, one entry per slot holding a used flag and the name.
// After reset, busy stays high while the RAM is swept clear; start is ignored
// during that pass. A transaction is accepted when start is high and busy is
// low. Busy then stays high through the home-slot calculation (the low slot
// bits of the folded sum when TABLE_SLOTS is a power of two, or byte folding,
// reciprocal multiply and remainder correction otherwise), the fill of the
// read pipeline and the walk over the slots probed (1..TABLE_SLOTS), one read
// per probe through the single RAM read port. The result is driven for
// exactly one cycle with out_valid, the first cycle in which busy is low; the
// receiver cannot stall it, so sample it then.
// ---------------------------------------------------------------------------
module name_table_probe_or_claim import ntpc_pkg::*; #(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [NAME_W-1:0]       in_name_word,
  input  logic [LEN_W-1:0]        in_name_length,
  output logic                    out_valid,
  output logic [SLOT_INDEX_W-1:0] out_slot_index,
  output logic                    out_claimed_new,
  output logic                    out_table_full
);

  `include "name_table_probe_or_claim_macros.svh"

  localparam int SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int ENTRY_W = NAME_W + 1;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_HASH  = 2'd2;
  localparam logic [1:0] ST_PROBE = 2'd3;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

  logic [1:0]              state_r, state_nxt;
  logic [NAME_W-1:0]       name_r, name_nxt;
  logic [SLOT_W-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [SLOT_W-1:0]       rd_pos_r, rd_pos_nxt;
  logic [SLOT_W-1:0]       eval_pos_r, eval_pos_nxt;
  logic                    eval_vld_r, eval_vld_nxt;
  logic [SLOT_W-1:0]       probes_r, probes_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [SLOT_INDEX_W-1:0] out_slot_index_r, out_slot_index_nxt;
  logic                    out_claimed_new_r, out_claimed_new_nxt;
  logic                    out_table_full_r, out_table_full_nxt;

  logic                    accept;
  logic [NAME_W-1:0]       masked_name;
  logic                    mod_done;
  logic [SLOT_W-1:0]       mod_home;

  logic                    ram_we;
  logic [SLOT_W-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]      ram_wdata;
  logic [ENTRY_W-1:0]      ram_rdata;
  logic                    slot_empty;
  logic                    slot_match;

  assign accept      = start && (state_r == ST_IDLE);
  assign masked_name = mask_name(in_name_word, in_name_length);

  // Home slot: hash, then remainder by the slot count.
  ntpc_hash_mod #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_hash_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .name_word(masked_name),
    .done     (mod_done),
    .home     (mod_home)
  );

  // Slot table: {used, name} per entry.
  ntpc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_pos_r),
    .rdata(ram_rdata)
  );

  assign slot_empty = !ram_rdata[NAME_W];
  assign slot_match = (ram_rdata[NAME_W-1:0] == name_r);

  always_comb begin
    state_nxt           = state_r;
    name_nxt            = name_r;
    clr_cnt_nxt         = clr_cnt_r;
    rd_pos_nxt          = rd_pos_r;
    eval_pos_nxt        = eval_pos_r;
    eval_vld_nxt        = eval_vld_r;
    probes_nxt          = probes_r;
    out_valid_nxt       = 1'b0;
    out_slot_index_nxt  = out_slot_index_r;
    out_claimed_new_nxt = out_claimed_new_r;
    out_table_full_nxt  = out_table_full_r;
    ram_we              = 1'b0;
    ram_waddr           = clr_cnt_r;
    ram_wdata           = '0;

    case (state_r)
      ST_CLEAR: begin
        // Sweep one entry per cycle to empty.
        ram_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_SLOT) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          name_nxt  = masked_name;
          state_nxt = ST_HASH;
        end
      end

      ST_HASH: begin
        // Hold until the home slot is ready, then seed the probe walk.
        if (mod_done) begin
          rd_pos_nxt   = mod_home;
          eval_vld_nxt = 1'b0;
          probes_nxt   = '0;
          state_nxt    = ST_PROBE;
        end
      end

      ST_PROBE: begin
        // Issue one read per cycle; judge the entry read the cycle before.
        rd_pos_nxt   = (rd_pos_r == LAST_SLOT) ? '0 : rd_pos_r + 1'b1;
        eval_pos_nxt = rd_pos_r;
        eval_vld_nxt = 1'b1;
        if (eval_vld_r) begin
          if (slot_empty) begin
            ram_we              = 1'b1;
            ram_waddr           = eval_pos_r;
            ram_wdata           = {1'b1, name_r};
            out_valid_nxt       = 1'b1;
            out_slot_index_nxt  = SLOT_INDEX_W'(eval_pos_r);
            out_claimed_new_nxt = 1'b1;
            out_table_full_nxt  = 1'b0;
            state_nxt           = ST_IDLE;
          end else if (slot_match) begin
            out_valid_nxt       = 1'b1;
            out_slot_index_nxt  = SLOT_INDEX_W'(eval_pos_r);
            out_claimed_new_nxt = 1'b0;
            out_table_full_nxt  = 1'b0;
            state_nxt           = ST_IDLE;
          end else if (probes_r == LAST_SLOT) begin
            out_valid_nxt       = 1'b1;
            out_slot_index_nxt  = '0;
            out_claimed_new_nxt = 1'b0;
            out_table_full_nxt  = 1'b1;
            state_nxt           = ST_IDLE;
          end else begin
            probes_nxt = probes_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      eval_vld_r  <= 1'b0;
      probes_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      eval_vld_r  <= eval_vld_nxt;
      probes_r    <= probes_nxt;
      out_valid_r <= out_valid_nxt;
    end
    name_r            <= name_nxt;
    rd_pos_r          <= rd_pos_nxt;
    eval_pos_r        <= eval_pos_nxt;
    out_slot_index_r  <= out_slot_index_nxt;
    out_claimed_new_r <= out_claimed_new_nxt;
    out_table_full_r  <= out_table_full_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_slot_index  = out_slot_index_r;
  assign out_claimed_new = out_claimed_new_r;
  assign out_table_full  = out_table_full_r;

  // A claim and a full table never come together.
  `NTPC_ASSERT_NOW(a_claim_not_full, out_valid,
                   !(out_claimed_new && out_table_full), "claim and full both set")
  // An accepted transaction makes the block busy.
  `NTPC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
  // The table is written only by the clear sweep or a probe decision.
  `NTPC_ASSERT_NOW(a_write_state, ram_we,
                   (state_r == ST_CLEAR) || (state_r == ST_PROBE),
                   "table write outside clear or probe")
  // A result strobe follows a probe decision.
  `NTPC_ASSERT_NOW(a_result_from_probe, out_valid, $past(state_r) == ST_PROBE,
                   "result without probe")

endmodule

@@ bench/tb_name_table_probe_or_claim.sv @@
// ---------------------------------------------------------------------------
// Name table probe-or-claim testbench
// Drives name lookups through the start/busy command port and keeps its own
// model of the slot table. Each returned slot result is compared, field by
// field, with the result that the model predicts. Stimulus runs from a short
// directed part (length masking, extreme bytes, wrap-around probe chains) to
// a long mix of repeated and fresh names, and ends with a table driven full.
// ---------------------------------------------------------------------------
module tb_name_table_probe_or_claim;
  timeunit 1ns;
  timeprecision 1ps;
  import ntpc_pkg::*;

  localparam int SLOTS       = DEF_TABLE_SLOTS;
  localparam int MAX_GAP     = 10;
  localparam int MIX_ITEMS   = 1600;
  localparam int POOL        = 96;
  // Worst item: the longest idle gap, a full-table probe walk and the result.
  // About 1700 items of that plus the clearing sweep, taken several times.
  localparam int CYCLE_LIMIT = 600000;
  // Quiet time after the last result: one full-table probe walk and margin.
  localparam int TAIL_CYCLES = SLOTS + 40;

  typedef struct packed {
    logic [SLOT_INDEX_W-1:0] slot;
    logic                    claimed;
    logic                    full;
  } slot_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [NAME_W-1:0]       in_name_word;
  logic [LEN_W-1:0]        in_name_length;
  logic                    out_valid;
  logic [SLOT_INDEX_W-1:0] out_slot_index;
  logic                    out_claimed_new;
  logic                    out_table_full;

  // Model of the slot table: stored names, used flags, count of used slots.
  logic [NAME_W-1:0] table_name [SLOTS];
  bit                table_used [SLOTS];
  int                slots_taken;

  // Slot results still owed by the block, oldest first.
  slot_result_t pending_slot_results[$];
  slot_result_t owed;

  int  mismatches;
  int  cycle_count;
  int  items_sent;
  int  seen_claims;
  int  seen_hits;
  int  seen_full;
  bit  back_to_back;

  name_table_probe_or_claim #(
    .TABLE_SLOTS(SLOTS)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_name_word   (in_name_word),
    .in_name_length (in_name_length),
    .out_valid      (out_valid),
    .out_slot_index (out_slot_index),
    .out_claimed_new(out_claimed_new),
    .out_table_full (out_table_full)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Table model
  // -------------------------------------------------------------------------

  // Keep only the bytes below the length; any length of 4 or more keeps all.
  function automatic logic [NAME_W-1:0] visible_name(input logic [NAME_W-1:0] word,
                                                     input logic [LEN_W-1:0]  len);
    logic [NAME_W-1:0] name;
    name = '0;
    for (int b = 0; b < 4; b++) begin
      if (b < len) name[8*b +: 8] = word[8*b +: 8];
    end
    return name;
  endfunction

  // Sum the bytes at shifts of 0, 7, 14 and 21, then reduce to a slot.
  function automatic int home_slot(input logic [NAME_W-1:0] name);
    int unsigned h;
    h = 0;
    for (int b = 0; b < 4; b++) begin
      h = h + (32'(name[8*b +: 8]) << (7*b));
    end
    return int'(h % SLOTS);
  endfunction

  // Walk from the home slot with wrap: stop at a matching used slot, or claim
  // the first empty one. A walk over the whole table with neither is full.
  function automatic slot_result_t probe_or_claim(input logic [NAME_W-1:0] word,
                                                  input logic [LEN_W-1:0]  len);
    logic [NAME_W-1:0] name;
    slot_result_t      res;
    int                pos;
    name = visible_name(word, len);
    pos  = home_slot(name);
    res  = '{slot: '0, claimed: 1'b0, full: 1'b1};
    for (int n = 0; n < SLOTS; n++) begin
      if (!table_used[pos]) begin
        table_name[pos] = name;
        table_used[pos] = 1'b1;
        slots_taken++;
        res = '{slot: SLOT_INDEX_W'(pos), claimed: 1'b1, full: 1'b0};
        return res;
      end
      if (table_name[pos] == name) begin
        res = '{slot: SLOT_INDEX_W'(pos), claimed: 1'b0, full: 1'b0};
        return res;
      end
      pos = (pos + 1) % SLOTS;
    end
    return res;
  endfunction

  // -------------------------------------------------------------------------
  // Command side
  // -------------------------------------------------------------------------

  // Present one lookup and hold it until the block takes it. Start stays high
  // after the transaction so a back-to-back lookup needs no second write of
  // it in the same step; a drain, or the next call when it waits a gap, lowers it.
  task automatic send_name(input logic [NAME_W-1:0] word, input logic [LEN_W-1:0] len);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_name_word   <= word;
    in_name_length <= len;
    @(posedge clk);
    // Busy is sampled before the block updates it, so this is the edge value.
    while (busy !== 1'b0) @(posedge clk);
    pending_slot_results.push_back(probe_or_claim(word, len));
    items_sent++;
  endtask

  // Drop start and hold off until every owed result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_slot_results.size() != 0) @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Lengths 0..4 and well past 4, all-ones and single-bit words, junk bytes
  // past the length. Names that mask to the same value must land on one slot;
  // the all-ones names all hash home to the last slot and wrap to the front.
  task automatic test_length_masking();
    logic [NAME_W-1:0] words [14];
    logic [LEN_W-1:0]  lens  [14];
    words = '{32'hFFFF_FFFF, 32'h1234_5678, 32'h0000_0000, 32'hFFFF_FFFF,
              32'hA5A5_A5FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h00FF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF};
    lens  = '{8'd0, 8'd0, 8'd4, 8'd1, 8'd1, 8'd2, 8'd3, 8'd4,
              8'd255, 8'd5, 8'd128, 8'd4, 8'd4, 8'd200};
    foreach (words[i]) send_name(words[i], lens[i]);
  endtask

  // Several names share a home slot near the end of the table; their chain
  // wraps past slots already taken at the front. Re-look one at the far end
  // of the chain so the block walks the whole run before it matches.
  task automatic test_probe_wrap();
    send_name(32'h0000_013E, 8'd4);
    send_name(32'h0000_023E, 8'd4);
    send_name(32'h0000_033E, 8'd4);
    send_name(32'hEE01_013E, 8'd3);
    send_name(32'h0000_033E, 8'd9);
    send_name(32'h5500_013E, 8'd2);
    send_name(32'h0001_013E, 8'd4);
  endtask

  // Mostly repeated names from a pool that widens over the run, so claims and
  // hits interleave and the table fills late. Half the pool is crowded onto
  // the last four home slots to build long chains across the wrap. Some
  // lookups carry junk past the length or a long alias length; a few are
  // fresh random words with any length.
  task automatic test_mixed_traffic();
    logic [NAME_W-1:0] pool_word [POOL];
    logic [LEN_W-1:0]  pool_len  [POOL];
    logic [NAME_W-1:0] word;
    logic [NAME_W-1:0] junk;
    logic [LEN_W-1:0]  len;
    int                reach;
    int                pick;
    int                kind;
    for (int p = 0; p < POOL; p++) begin
      pool_word[p] = $urandom;
      pool_len[p]  = 8'($urandom_range(1, 4));
      // With 64 slots the home slot is the low six bits of byte 0.
      if (p % 2 == 0) pool_word[p][5:0] = 6'(60 + $urandom_range(0, 3));
    end
    for (int i = 0; i < MIX_ITEMS; i++) begin
      if (i % 100 == 0) back_to_back = ($urandom_range(0, 2) == 0);
      if (i > 0 && i % 400 == 0) drain_results();
      reach = (i * POOL) / 1200;
      if (reach > POOL - 1) reach = POOL - 1;
      pick = $urandom_range(0, reach);
      kind = $urandom_range(0, 99);
      word = pool_word[pick];
      len  = pool_len[pick];
      if (kind < 2) begin
        word = $urandom;
        len  = 8'($urandom_range(0, 255));
      end else if (kind < 40) begin
        junk = $urandom;
        for (int b = 0; b < 4; b++) begin
          if (b >= len) word[8*b +: 8] = junk[8*b +: 8];
        end
        if (len == 8'd4) len = 8'($urandom_range(4, 255));
      end
      send_name(word, len);
    end
    back_to_back = 1'b0;
  endtask

  // Claim fresh names until every slot is used, then check that new names get
  // the full flag and that stored names are still found.
  task automatic test_fill_to_capacity();
    int guard;
    int s;
    guard = 0;
    while (slots_taken < SLOTS && guard < 4 * SLOTS) begin
      send_name($urandom, 8'($urandom_range(4, 255)));
      guard++;
    end
    repeat (8) send_name($urandom, 8'($urandom_range(1, 255)));
    repeat (8) begin
      s = $urandom_range(0, SLOTS - 1);
      send_name(table_name[s], 8'($urandom_range(4, 255)));
    end
  endtask

  // -------------------------------------------------------------------------
  // Result checking: the result is up for one cycle and cannot be stalled,
  // so sample it at the edge that ends that cycle.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_slot_results.size() == 0) begin
        $error("slot result with no lookup pending: out_slot_index %0d", out_slot_index);
        mismatches++;
      end else begin
        owed = pending_slot_results.pop_front();
        if (out_slot_index !== owed.slot) begin
          $error("out_slot_index: expected %0d, got %0d", owed.slot, out_slot_index);
          mismatches++;
        end
        if (out_claimed_new !== owed.claimed) begin
          $error("out_claimed_new: expected %0b, got %0b", owed.claimed, out_claimed_new);
          mismatches++;
        end
        if (out_table_full !== owed.full) begin
          $error("out_table_full: expected %0b, got %0b", owed.full, out_table_full);
          mismatches++;
        end
        if (owed.full) seen_full++;
        else if (owed.claimed) seen_claims++;
        else seen_hits++;
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Sequence
  // -------------------------------------------------------------------------
  initial begin
    start          <= 1'b0;
    in_name_word   <= '0;
    in_name_length <= '0;
    rst_n          <= 1'b0;
    back_to_back    = 1'b0;
    slots_taken     = 0;
    foreach (table_used[i]) begin
      table_used[i] = 1'b0;
      table_name[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // Let the first edge out of reset pass; send_name then waits out the
    // clearing sweep on busy.
    @(posedge clk);

    test_length_masking();
    test_probe_wrap();
    drain_results();
    test_mixed_traffic();
    drain_results();
    test_fill_to_capacity();
    drain_results();

    // Give a late or stray result time to show up.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d lookups: %0d claims, %0d hits, %0d table-full replies checked.",
             items_sent, seen_claims, seen_hits, seen_full);
    $display("Lengths 0..255 with junk past the length, wrapped probe chains, full table.");
    if (mismatches == 0 && pending_slot_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
